// File: design/lpi_pkg.sv
// shared constants for the line/plane intersection block
package lpi_pkg;

  localparam int TOL_BITS  = 31;
  localparam int ADDR_BITS = 3;
  localparam int KIND_BITS = 2;

  localparam logic [ADDR_BITS-1:0] REG_PLANE_ORIGIN_X = 3'd0;
  localparam logic [ADDR_BITS-1:0] REG_PLANE_ORIGIN_Y = 3'd1;
  localparam logic [ADDR_BITS-1:0] REG_PLANE_ORIGIN_Z = 3'd2;
  localparam logic [ADDR_BITS-1:0] REG_PLANE_NORMAL_X = 3'd3;
  localparam logic [ADDR_BITS-1:0] REG_PLANE_NORMAL_Y = 3'd4;
  localparam logic [ADDR_BITS-1:0] REG_PLANE_NORMAL_Z = 3'd5;
  localparam logic [ADDR_BITS-1:0] REG_TOLERANCE      = 3'd6;

  localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_POINT = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_LINE  = 2'd2;

endpackage

// File: design/lpi_front.sv
// dot products u = n.d and s = n.(p - o), magnitudes and parallel test
module lpi_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [8*WORD_BITS-1:0]              in_data,
  input  logic signed [WORD_BITS-1:0]         po_x,
  input  logic signed [WORD_BITS-1:0]         po_y,
  input  logic signed [WORD_BITS-1:0]         po_z,
  input  logic signed [WORD_BITS-1:0]         pn_x,
  input  logic signed [WORD_BITS-1:0]         pn_y,
  input  logic signed [WORD_BITS-1:0]         pn_z,
  input  logic [lpi_pkg::TOL_BITS-1:0]        tol,
  output logic                                out_valid,
  output logic                                nz,
  output logic                                neg,
  output logic [2*WORD_BITS-FRAC_BITS+1:0]    nu,
  output logic [2*WORD_BITS-FRAC_BITS+2:0]    ns,
  output logic [lpi_pkg::KIND_BITS-1:0]       par_kind,
  output logic signed [WORD_BITS-1:0]         pmin,
  output logic signed [WORD_BITS-1:0]         pmax
);
  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int UW  = 2*W-F+2;
  localparam int SW  = 2*W-F+3;
  localparam int PUW = 2*W-F;
  localparam int PSW = 2*W+1-F;
  localparam int TB  = lpi_pkg::TOL_BITS;
  localparam int AW  = (SW > TB) ? SW : TB;

  logic [2:0] vld;
  logic signed [W-1:0]   d0 [3];
  logic signed [W:0]     v0 [3];
  logic signed [2*W-1:0] pu [3];
  logic signed [2*W:0]   ps [3];
  logic signed [UW-1:0]  u;
  logic signed [SW-1:0]  s;
  logic signed [W-1:0]   pmin_p [3];
  logic signed [W-1:0]   pmax_p [3];
  logic signed [PUW-1:0] fu [3];
  logic signed [PSW-1:0] fs [3];
  logic [UW-1:0] au;
  logic [SW-1:0] as_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fu[i] = PUW'(pu[i] >>> F);
      fs[i] = PSW'(ps[i] >>> F);
    end
    au   = u[UW-1] ? UW'(-u) : UW'(u);
    as_s = s[SW-1] ? SW'(-s) : SW'(s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: direction and plane-minus-origin vector
      d0[0] <= $signed(in_data[3*W +: W]);
      d0[1] <= $signed(in_data[4*W +: W]);
      d0[2] <= $signed(in_data[5*W +: W]);
      v0[0] <= (W+1)'(po_x) - (W+1)'($signed(in_data[0*W +: W]));
      v0[1] <= (W+1)'(po_y) - (W+1)'($signed(in_data[1*W +: W]));
      v0[2] <= (W+1)'(po_z) - (W+1)'($signed(in_data[2*W +: W]));
      pmin_p[0] <= $signed(in_data[6*W +: W]);
      pmax_p[0] <= $signed(in_data[7*W +: W]);
      // stage 1: exact products
      pu[0] <= d0[0] * pn_x;
      pu[1] <= d0[1] * pn_y;
      pu[2] <= d0[2] * pn_z;
      ps[0] <= v0[0] * pn_x;
      ps[1] <= v0[1] * pn_y;
      ps[2] <= v0[2] * pn_z;
      pmin_p[1] <= pmin_p[0];
      pmax_p[1] <= pmax_p[0];
      // stage 2: floor-shifted sums
      u <= UW'(fu[0]) + UW'(fu[1]) + UW'(fu[2]);
      s <= SW'(fs[0]) + SW'(fs[1]) + SW'(fs[2]);
      pmin_p[2] <= pmin_p[1];
      pmax_p[2] <= pmax_p[1];
      // stage 3: magnitudes and parallel decision
      nu       <= au;
      ns       <= as_s;
      neg      <= u[UW-1] ^ s[SW-1];
      nz       <= (u != '0) && (AW'(au) >= AW'(tol));
      par_kind <= (AW'(as_s) < AW'(tol)) ? lpi_pkg::KIND_LINE : lpi_pkg::KIND_NONE;
      pmin     <= pmin_p[2];
      pmax     <= pmax_p[2];
    end
  end

endmodule

// File: design/lpi_div_cell.sv
// one restoring division step: one quotient bit per cell
module lpi_div_cell #(
  parameter int RW     = 67,
  parameter int QW     = 32,
  parameter int SIDE_W = 69
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [RW-1:0]     rin,
  input  logic [RW-1:0]     din,
  input  logic [QW-1:0]     qin,
  input  logic [SIDE_W-1:0] sin,
  output logic              vout,
  output logic [RW-1:0]     rout,
  output logic [RW-1:0]     dout,
  output logic [QW-1:0]     qout,
  output logic [SIDE_W-1:0] sout
);
  logic [RW:0] t;
  logic [RW:0] diff;
  logic        ge;

  always_comb begin
    t    = {rin, 1'b0};
    diff = t - {1'b0, din};
    ge   = (t >= {1'b0, din});
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= vin;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rout <= ge ? diff[RW-1:0] : t[RW-1:0];
      dout <= din;
      qout <= {qin[QW-2:0], ge};
      sout <= sin;
    end
  end

endmodule

// File: design/line_plane_intersect.sv
// top level: line/plane intersection, pipelined with a chain of divider cells
//
// Config: write plane origin, unit normal and tolerance through cfg_we,
// cfg_addr, cfg_data (0..2 origin x/y/z, 3..5 normal x/y/z, 6 tolerance),
// only while no beat is in flight. Reset puts the normal at +z (1.0),
// origin at 0 and tolerance at one lsb, and empties the pipeline.
// Input beat: s_tdata carries line origin, direction and the parameter
// window. Output beat: m_tuser holds hit_kind, m_tdata holds hit_param.
// The pipeline runs the dot products, one overflow check, one cell per
// quotient bit, then saturation and the window test. Throughput is one
// beat per cycle while the receiver does not stall.
// The whole pipeline advances when the output register is empty or is
// being taken; when the receiver stalls with a result waiting, s_tready
// drops and every stage holds.
module line_plane_intersect #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lpi_pkg::ADDR_BITS-1:0]       cfg_addr,
  input  logic [((WORD_BITS > lpi_pkg::TOL_BITS) ? WORD_BITS : lpi_pkg::TOL_BITS)-1:0]
                                              cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // line_origin_x, y, z, line_dir_x, y, z, param_min, param_max
  input  logic [8*WORD_BITS-1:0]              s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // hit_param, zero filled to whole bytes
  output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,
  // hit_kind
  output logic [lpi_pkg::KIND_BITS-1:0]       m_tuser
);
  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int TB  = lpi_pkg::TOL_BITS;
  localparam int KB  = lpi_pkg::KIND_BITS;
  localparam int UW  = 2*W-F+2;
  localparam int SW  = 2*W-F+3;
  localparam int RA  = SW+F;
  localparam int RB  = UW+W;
  localparam int RW  = (RA > RB) ? RA : RB;
  localparam int SIDE_W = 4+KB+2*W;
  localparam int EWB = (W > TB) ? W : TB;
  localparam int EW  = EWB+3;
  localparam int OB  = ((W+7)/8)*8;

  logic signed [W-1:0] po_x, po_y, po_z, pn_x, pn_y, pn_z;
  logic [TB-1:0] tol;
  logic en;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      po_x <= '0;
      po_y <= '0;
      po_z <= '0;
      pn_x <= '0;
      pn_y <= '0;
      pn_z <= W'(1) << F;
      tol  <= TB'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        lpi_pkg::REG_PLANE_ORIGIN_X: po_x <= $signed(cfg_data[W-1:0]);
        lpi_pkg::REG_PLANE_ORIGIN_Y: po_y <= $signed(cfg_data[W-1:0]);
        lpi_pkg::REG_PLANE_ORIGIN_Z: po_z <= $signed(cfg_data[W-1:0]);
        lpi_pkg::REG_PLANE_NORMAL_X: pn_x <= $signed(cfg_data[W-1:0]);
        lpi_pkg::REG_PLANE_NORMAL_Y: pn_y <= $signed(cfg_data[W-1:0]);
        lpi_pkg::REG_PLANE_NORMAL_Z: pn_z <= $signed(cfg_data[W-1:0]);
        lpi_pkg::REG_TOLERANCE:      tol  <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_nz, f_neg;
  logic [UW-1:0] f_nu;
  logic [SW-1:0] f_ns;
  logic [KB-1:0] f_kind;
  logic signed [W-1:0] f_pmin, f_pmax;

  lpi_front #(.WORD_BITS(W), .FRAC_BITS(F)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_data(s_tdata),
    .po_x(po_x), .po_y(po_y), .po_z(po_z),
    .pn_x(pn_x), .pn_y(pn_y), .pn_z(pn_z), .tol(tol),
    .out_valid(f_valid), .nz(f_nz), .neg(f_neg), .nu(f_nu), .ns(f_ns),
    .par_kind(f_kind), .pmin(f_pmin), .pmax(f_pmax)
  );

  // divider setup: remainder ns<<F against divisor nu<<W, overflow if not below
  logic [RW-1:0] r0, dv0;
  logic [RW-1:0] r_init, d_init;
  logic v_init;
  logic [SIDE_W-1:0] side_init;

  assign r0  = RW'(f_ns) << F;
  assign dv0 = RW'(f_nu) << W;

  always_ff @(posedge clk) begin
    if (rst) v_init <= 1'b0;
    else if (en) v_init <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_init    <= r0;
      d_init    <= dv0;
      side_init <= {f_pmax, f_pmin, f_kind, (r0 >= dv0), f_neg, f_nz, 1'b0};
    end
  end

  logic              cv [W+1];
  logic [RW-1:0]     cr [W+1];
  logic [RW-1:0]     cd [W+1];
  logic [W-1:0]      cq [W+1];
  logic [SIDE_W-1:0] cs [W+1];

  assign cv[0] = v_init;
  assign cr[0] = r_init;
  assign cd[0] = d_init;
  assign cq[0] = '0;
  assign cs[0] = side_init;

  for (genvar k = 0; k < W; k++) begin : g_cell
    lpi_div_cell #(.RW(RW), .QW(W), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(cv[k]), .rin(cr[k]), .din(cd[k]), .qin(cq[k]), .sin(cs[k]),
      .vout(cv[k+1]), .rout(cr[k+1]), .dout(cd[k+1]), .qout(cq[k+1]), .sout(cs[k+1])
    );
  end

  // side vector fields, lowest bit up: spare, nz, neg, ovf, kind, pmin, pmax
  logic [SIDE_W-1:0] se;
  logic e_nz, e_neg, e_ovf, e_spare;
  logic [KB-1:0] e_kind;
  logic signed [W-1:0] e_pmin, e_pmax;
  logic [W-1:0] lim, qs;

  assign se = cs[W];
  assign {e_pmax, e_pmin, e_kind, e_ovf, e_neg, e_nz, e_spare} = se;
  assign lim = e_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign qs  = (e_ovf || (cq[W] > lim)) ? lim : cq[W];

  logic t_valid, t_nz;
  logic signed [W-1:0] t_w, t_pmin, t_pmax;
  logic [KB-1:0] t_kind;

  always_ff @(posedge clk) begin
    if (rst) t_valid <= 1'b0;
    else if (en) t_valid <= cv[W] && !e_spare;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_w    <= !e_nz ? '0 : (e_neg ? $signed(-qs) : $signed(qs));
      t_nz   <= e_nz;
      t_kind <= e_kind;
      t_pmin <= e_pmin;
      t_pmax <= e_pmax;
    end
  end

  // window test widened by the tolerance
  logic signed [EW-1:0] lo_diff, hi_diff, tol_e;
  logic [KB-1:0] kind_next;

  always_comb begin
    tol_e   = EW'($signed({1'b0, tol}));
    lo_diff = EW'(t_w) - EW'(t_pmin) + tol_e;
    hi_diff = EW'(t_w) - EW'(t_pmax) - tol_e;
    if (t_nz) begin
      kind_next = ((lo_diff > 0) && (hi_diff < 0)) ? lpi_pkg::KIND_POINT
                                                   : lpi_pkg::KIND_NONE;
    end else begin
      kind_next = t_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= t_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OB'(unsigned'(t_w));
      m_tuser <= kind_next;
    end
  end

endmodule
